// ===== hdl/ukrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukrt_pkg
// Shared types and codes for the unique key record table.
// ----------------------------------------------------------------------------
package ukrt_pkg;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_DUMP   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] key;
    logic [63:0] model_text;
    logic [7:0]  tank_capacity;
    logic [7:0]  seat_count;
    logic [15:0] engine_cc;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_key;
    logic [63:0] out_model;
    logic [7:0]  out_tank;
    logic [7:0]  out_seats;
    logic [15:0] out_engine;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] key;
    logic [63:0] model;
    logic [7:0]  tank;
    logic [7:0]  seats;
    logic [15:0] engine;
  } rec_t;

  typedef struct packed {
    logic step;
    logic drop;
    logic load_new;
  } cell_ctl_t;

endpackage

// ===== hdl/ukrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukrt_cell
// One record slot of the table ring; takes its neighbor's record on each step.
// ----------------------------------------------------------------------------
module ukrt_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 5
) (
  input  logic                clk,
  input  ukrt_pkg::cell_ctl_t ctl,
  input  logic [COUNT_W-1:0]  count,
  input  ukrt_pkg::rec_t      rec_next,
  input  ukrt_pkg::rec_t      rec_head,
  input  ukrt_pkg::rec_t      rec_new,
  output ukrt_pkg::rec_t      rec_q
);

  ukrt_pkg::rec_t rec_r;
  logic           is_slot;
  logic           is_tail;

  assign is_slot = (count == COUNT_W'(IDX));
  assign is_tail = (count == COUNT_W'(IDX + 1));
  assign rec_q   = rec_r;

  // The tail closes the ring onto the head unless the head is being dropped.
  always_ff @(posedge clk) begin
    if (ctl.load_new && is_slot) begin
      rec_r <= rec_new;
    end else if (ctl.step) begin
      rec_r <= (ctl.drop || !is_tail) ? rec_next : rec_head;
    end
  end

endmodule

// ===== hdl/unique_key_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_record_table
// Packed record table with unique keys: lookup, insert, delete and dump.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | in_valid, in_ready, in_data    | ukrt_pkg::in_word_t
//  result  | out_valid, out_ready, out_data | ukrt_pkg::out_word_t
//
// Records sit in a ring of cells that rotates by one entry per cycle while a word
// is scanned or dumped (a dump stalls with the output), and the head cell is
// compared against the key. Lookup, insert and delete scan all N stored records;
// a dump emits them in order. An insert into a full table or a dump of an empty
// one goes straight to the result. One word is worked on at a time. Reset empties the table.
// A finished word waits in the output register while the next one is taken.
module unique_key_record_table #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ukrt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ukrt_pkg::out_word_t out_data
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_DONE
  } state_t;

  state_t              state_r;
  ukrt_pkg::in_word_t  req_r;
  logic [COUNT_W-1:0]  count_r;
  logic [COUNT_W-1:0]  n_r;
  logic [COUNT_W-1:0]  step_r;
  logic                found_r;
  ukrt_pkg::rec_t      hit_r;
  ukrt_pkg::out_word_t res_r;
  logic                out_valid_r;
  ukrt_pkg::out_word_t out_data_r;

  ukrt_pkg::rec_t      recs [CAPACITY];
  ukrt_pkg::rec_t      new_rec;
  ukrt_pkg::cell_ctl_t ctl;
  logic                slot_free;
  logic                out_load;
  logic                scan_end;
  logic                hit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign new_rec.key    = req_r.key;
  assign new_rec.model  = req_r.model_text;
  assign new_rec.tank   = req_r.tank_capacity;
  assign new_rec.seats  = req_r.seat_count;
  assign new_rec.engine = req_r.engine_cc;

  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = slot_free && ((state_r == S_EMIT) || (state_r == S_DONE));
  assign scan_end  = (step_r == n_r);
  assign hit       = !found_r && (recs[0].key == req_r.key);

  always_comb begin
    ctl.step     = ((state_r == S_SCAN) && !scan_end) || ((state_r == S_EMIT) && slot_free);
    ctl.drop     = (state_r == S_SCAN) && !scan_end && hit &&
                   (req_r.mode == ukrt_pkg::MODE_DELETE);
    ctl.load_new = (state_r == S_SCAN) && scan_end && !found_r &&
                   (req_r.mode == ukrt_pkg::MODE_INSERT);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NXT = (i + 1) % CAPACITY;
    ukrt_cell #(
      .IDX     (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .rec_next (recs[NXT]),
      .rec_head (recs[0]),
      .rec_new  (new_rec),
      .rec_q    (recs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            step_r  <= '0;
            n_r     <= count_r;
            found_r <= 1'b0;
            if ((in_data.mode == ukrt_pkg::MODE_DUMP) && (count_r == '0)) begin
              res_r <= '{status: ukrt_pkg::ST_EMPTY, out_key: '0, out_model: '0,
                         out_tank: '0, out_seats: '0, out_engine: '0, last: 1'b1};
            end else begin
              res_r <= '{status: ukrt_pkg::ST_FULL, out_key: in_data.key, out_model: '0,
                         out_tank: '0, out_seats: '0, out_engine: '0, last: 1'b1};
            end
            if (in_data.mode == ukrt_pkg::MODE_DUMP) begin
              if (count_r == '0) begin
                state_r <= S_DONE;
              end else begin
                state_r <= S_EMIT;
              end
            end else if ((in_data.mode == ukrt_pkg::MODE_INSERT) &&
                         (count_r == COUNT_W'(CAPACITY))) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            if ((req_r.mode == ukrt_pkg::MODE_INSERT) && !found_r) begin
              res_r   <= '{status: ukrt_pkg::ST_OK, out_key: req_r.key,
                           out_model: new_rec.model, out_tank: new_rec.tank,
                           out_seats: new_rec.seats, out_engine: new_rec.engine,
                           last: 1'b1};
              count_r <= count_r + COUNT_W'(1);
            end else if ((req_r.mode != ukrt_pkg::MODE_INSERT) && found_r) begin
              res_r <= '{status: ukrt_pkg::ST_OK, out_key: hit_r.key,
                         out_model: hit_r.model, out_tank: hit_r.tank,
                         out_seats: hit_r.seats, out_engine: hit_r.engine,
                         last: 1'b1};
            end else if (req_r.mode == ukrt_pkg::MODE_INSERT) begin
              res_r <= '{status: ukrt_pkg::ST_DUPLICATE, out_key: req_r.key,
                         out_model: '0, out_tank: '0, out_seats: '0,
                         out_engine: '0, last: 1'b1};
            end else begin
              res_r <= '{status: ukrt_pkg::ST_NOT_FOUND, out_key: req_r.key,
                         out_model: '0, out_tank: '0, out_seats: '0,
                         out_engine: '0, last: 1'b1};
            end
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + COUNT_W'(1);
            if (hit) begin
              found_r <= 1'b1;
              hit_r   <= recs[0];
              if (req_r.mode == ukrt_pkg::MODE_DELETE) begin
                count_r <= count_r - COUNT_W'(1);
              end
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_data_r  <= '{status: ukrt_pkg::ST_OK, out_key: recs[0].key,
                             out_model: recs[0].model, out_tank: recs[0].tank,
                             out_seats: recs[0].seats, out_engine: recs[0].engine,
                             last: (step_r + COUNT_W'(1) == n_r)};
            step_r      <= step_r + COUNT_W'(1);
            if (step_r + COUNT_W'(1) == n_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
